// ----- rtl/aml_sleep_type_scanner_defines.svh -----
// Assertion macros shared by the sleep-type scanner modules.
`ifndef AML_SLEEP_TYPE_SCANNER_DEFINES_SVH
`define AML_SLEEP_TYPE_SCANNER_DEFINES_SVH

// Same-cycle implication, checked on clk and disabled while rst_n is low.
`define AML_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk and disabled while rst_n is low.
`define AML_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/aml_sts_pkg.sv -----
// Types and constants shared by the sleep-type scanner modules.
`timescale 1ns / 1ps

package aml_sts_pkg;

  localparam int POSITION_BITS_DEF = 20;
  localparam int BODY_LEN_W        = 20;
  localparam int TARGET_W          = 3;
  localparam int CFG_DATA_W        = 20;

  localparam logic [7:0] BYTE_PREFIX     = 8'h0A;
  localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CHAR_S          = 8'h53;
  localparam logic [7:0] CHAR_ZERO       = 8'h30;

  localparam logic [TARGET_W-1:0] TARGET_RESET = 3'd3;

  // Configuration register indexes.
  typedef enum logic {
    REG_BODY_LENGTH  = 1'b0,
    REG_TARGET_STATE = 1'b1
  } cfg_reg_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_FOUND        = 2'd0,
    ST_NOT_FOUND    = 2'd1,
    ST_OUT_OF_TABLE = 2'd2
  } status_t;

  // Parse phases of the scan.
  typedef enum logic [3:0] {
    PH_SEARCH   = 4'd0,
    PH_PKG_OP   = 4'd1,
    PH_LEAD     = 4'd2,
    PH_LENGTH   = 4'd3,
    PH_COUNT    = 4'd4,
    PH_PREFIX_A = 4'd5,
    PH_VALUE_A  = 4'd6,
    PH_PREFIX_B = 4'd7,
    PH_VALUE_B  = 4'd8,
    PH_DONE     = 4'd9
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } in_item_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] sleep_type_a;
    logic [7:0] sleep_type_b;
  } out_item_t;

  // Result handed from the parser to the output queue.
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } res_t;

endpackage

// ----- rtl/aml_sts_core.sv -----
// Byte parser: configuration registers, name match and package walk.
`timescale 1ns / 1ps
`include "aml_sleep_type_scanner_defines.svh"

module aml_sts_core #(
  parameter int POSITION_BITS = aml_sts_pkg::POSITION_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [aml_sts_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                              accept,
  input  aml_sts_pkg::in_item_t             in_item,
  output aml_sts_pkg::res_t                 res
);

  // Compare width holds the position, the table length and a small offset.
  localparam int CW = ((POSITION_BITS > aml_sts_pkg::BODY_LEN_W) ?
                       POSITION_BITS : aml_sts_pkg::BODY_LEN_W) + 3;

  logic [aml_sts_pkg::BODY_LEN_W-1:0] body_len_r;
  logic [aml_sts_pkg::TARGET_W-1:0]   target_r;

  aml_sts_pkg::phase_t     phase_r, phase_nxt, cur_phase;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt, cur_pos;
  logic [23:0]              recent_r, recent_nxt, cur_recent, pattern;
  logic [1:0]               left_r, left_nxt, cur_left, lead_k;
  logic [7:0]               held_r, held_nxt, cur_held, type_b, d;
  logic [CW-1:0]            posx, blx;
  logic                     stepped, have_status;
  aml_sts_pkg::status_t     status;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      body_len_r <= '0;
      target_r   <= aml_sts_pkg::TARGET_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        aml_sts_pkg::REG_BODY_LENGTH:  body_len_r <= cfg_wdata;
        aml_sts_pkg::REG_TARGET_STATE: target_r   <= cfg_wdata[aml_sts_pkg::TARGET_W-1:0];
      endcase
    end
  end

  // Scan state registers, updated once per accepted item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= aml_sts_pkg::PH_SEARCH;
      pos_r    <= '0;
      recent_r <= '0;
      left_r   <= '0;
      held_r   <= '0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      recent_r <= recent_nxt;
      left_r   <= left_nxt;
      held_r   <= held_nxt;
    end
  end

  // A restart byte sees the scan state as freshly cleared.
  always_comb begin
    d          = in_item.data_byte;
    cur_phase  = in_item.restart ? aml_sts_pkg::PH_SEARCH : phase_r;
    cur_pos    = in_item.restart ? '0 : pos_r;
    cur_recent = in_item.restart ? '0 : recent_r;
    cur_left   = in_item.restart ? '0 : left_r;
    cur_held   = in_item.restart ? '0 : held_r;
    posx       = CW'(cur_pos);
    blx        = CW'(body_len_r);
    lead_k     = d[7:6];
    pattern    = {aml_sts_pkg::CHAR_UNDERSCORE, aml_sts_pkg::CHAR_S,
                  aml_sts_pkg::CHAR_ZERO + 8'(target_r)};
  end

  // Next phase and result for the current byte.
  always_comb begin
    phase_nxt   = cur_phase;
    pos_nxt     = cur_pos;
    recent_nxt  = cur_recent;
    left_nxt    = cur_left;
    held_nxt    = cur_held;
    type_b      = '0;
    stepped     = 1'b1;
    have_status = 1'b0;
    status      = aml_sts_pkg::ST_FOUND;

    unique case (cur_phase)
      aml_sts_pkg::PH_SEARCH: begin
        if (cur_recent == pattern && d == aml_sts_pkg::CHAR_UNDERSCORE &&
            posx + CW'(5) < blx) begin
          phase_nxt = aml_sts_pkg::PH_PKG_OP;
        end
      end
      aml_sts_pkg::PH_PKG_OP: phase_nxt = aml_sts_pkg::PH_LEAD;
      aml_sts_pkg::PH_LEAD: begin
        if (!(posx + CW'(3) + CW'(lead_k) < blx)) begin
          have_status = 1'b1;
          status      = aml_sts_pkg::ST_OUT_OF_TABLE;
        end else if (lead_k == 2'd0) begin
          phase_nxt = aml_sts_pkg::PH_COUNT;
        end else begin
          left_nxt  = lead_k;
          phase_nxt = aml_sts_pkg::PH_LENGTH;
        end
      end
      aml_sts_pkg::PH_LENGTH: begin
        left_nxt = cur_left - 2'd1;
        if (left_nxt == 2'd0) begin
          phase_nxt = aml_sts_pkg::PH_COUNT;
        end
      end
      aml_sts_pkg::PH_COUNT: phase_nxt = aml_sts_pkg::PH_PREFIX_A;
      aml_sts_pkg::PH_PREFIX_A: begin
        if (d == aml_sts_pkg::BYTE_PREFIX) begin
          phase_nxt = aml_sts_pkg::PH_VALUE_A;
        end else begin
          held_nxt  = d;
          phase_nxt = aml_sts_pkg::PH_PREFIX_B;
        end
      end
      aml_sts_pkg::PH_VALUE_A: begin
        held_nxt  = d;
        phase_nxt = aml_sts_pkg::PH_PREFIX_B;
      end
      aml_sts_pkg::PH_PREFIX_B: begin
        if (d == aml_sts_pkg::BYTE_PREFIX) begin
          phase_nxt = aml_sts_pkg::PH_VALUE_B;
        end else begin
          type_b      = d;
          have_status = 1'b1;
        end
      end
      aml_sts_pkg::PH_VALUE_B: begin
        type_b      = d;
        have_status = 1'b1;
      end
      default: begin
        // Scan finished (or a code with no meaning): bytes are ignored.
        phase_nxt = aml_sts_pkg::PH_DONE;
        stepped   = 1'b0;
      end
    endcase

    if (stepped) begin
      recent_nxt = {cur_recent[15:0], d};
      // The last byte of the table ends any scan still in progress.
      if (!have_status && posx + CW'(1) >= blx) begin
        have_status = 1'b1;
        status      = (phase_nxt == aml_sts_pkg::PH_SEARCH) ?
                      aml_sts_pkg::ST_NOT_FOUND : aml_sts_pkg::ST_OUT_OF_TABLE;
      end
      if (cur_pos != '1) begin
        pos_nxt = cur_pos + POSITION_BITS'(1);
      end
      if (have_status) begin
        phase_nxt = aml_sts_pkg::PH_DONE;
      end
    end
  end

  // Result toward the output queue; the types read zero on an error.
  always_comb begin
    res.valid             = accept && stepped && have_status;
    res.item.status       = status;
    res.item.sleep_type_a = (status == aml_sts_pkg::ST_FOUND) ? held_nxt : '0;
    res.item.sleep_type_b = (status == aml_sts_pkg::ST_FOUND) ? type_b : '0;
  end

  `AML_ASSERT_NEXT(a_done_after_result, res.valid, phase_r == aml_sts_pkg::PH_DONE, "scan did not finish after its result")
  `AML_ASSERT_IMPL(a_quiet_when_done, accept && !in_item.restart && phase_r == aml_sts_pkg::PH_DONE, !res.valid, "result emitted after the scan finished")

endmodule

// ----- rtl/aml_sts_out.sv -----
// Two-entry output queue between the parser and the result channel.
`timescale 1ns / 1ps
`include "aml_sleep_type_scanner_defines.svh"

module aml_sts_out (
  input  logic                   clk,
  input  logic                   rst_n,
  input  aml_sts_pkg::res_t      res,
  output logic                   full,
  output logic                   out_valid,
  input  logic                   out_stall,
  output aml_sts_pkg::out_item_t out_item
);

  aml_sts_pkg::out_item_t slot0_r, slot0_nxt, slot1_r, slot1_nxt;
  logic [1:0]             cnt_r, cnt_nxt;
  logic                   push, pop;

  assign push      = res.valid;
  assign pop       = out_valid && !out_stall;
  assign out_valid = (cnt_r != 2'd0);
  assign full      = (cnt_r == 2'd2);
  assign out_item  = slot0_r;

  // Queue bookkeeping: the head sits in slot0, the next item in slot1.
  always_comb begin
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    cnt_nxt   = cnt_r;
    priority if (push && pop) begin
      if (cnt_r == 2'd2) begin
        slot0_nxt = slot1_r;
        slot1_nxt = res.item;
      end else begin
        slot0_nxt = res.item;
      end
    end else if (pop) begin
      slot0_nxt = slot1_r;
      cnt_nxt   = cnt_r - 2'd1;
    end else if (push) begin
      if (cnt_r == 2'd0) begin
        slot0_nxt = res.item;
      end else begin
        slot1_nxt = res.item;
      end
      cnt_nxt = cnt_r + 2'd1;
    end else begin
      // Neither side moves: the queue holds its contents.
      cnt_nxt = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Payload slots carry no reset.
  always_ff @(posedge clk) begin
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

  `AML_ASSERT_IMPL(a_no_push_when_full, push, cnt_r != 2'd2, "result pushed into a full queue")
  `AML_ASSERT_NEXT(a_pop_drains, pop && !push, cnt_r == $past(cnt_r) - 2'd1, "queue count did not drop on a pop")

endmodule

// ----- rtl/aml_sleep_type_scanner.sv -----
// Top level of the sleep-type scanner for the AML body of a DSDT table.
`timescale 1ns / 1ps

// The block takes table body bytes one item per cycle and, per scan, returns
// one result item: the sleep type bytes for control blocks A and B of the
// '_Sn_' package, or a not-found or out-of-table status. Every byte is parsed
// in the cycle it is accepted, so the sustained rate is one item per clock
// while in_stall is low; the result that a byte causes is registered in the
// output queue before it appears on the output. Results wait in a two-entry
// output queue, and in_stall rises only when both entries are full. Set
// body_length and target_state while idle; a byte with restart set begins a
// new scan at body offset zero. No clearing pass follows reset.
module aml_sleep_type_scanner #(
  parameter int POSITION_BITS = aml_sts_pkg::POSITION_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic [aml_sts_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  aml_sts_pkg::in_item_t              in_item,
  output logic                               out_valid,
  input  logic                               out_stall,
  output aml_sts_pkg::out_item_t             out_item
);

  aml_sts_pkg::res_t res;
  logic              full, accept;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  // Byte parser.
  aml_sts_core #(
    .POSITION_BITS (POSITION_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .in_item   (in_item),
    .res       (res)
  );

  // Output queue.
  aml_sts_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// ----- dv/sleep_type_checker.sv -----
// Checker for the sleep-type scanner: predicts each result item and compares it.
`timescale 1ns / 1ps

module sleep_type_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic [aml_sts_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  aml_sts_pkg::in_item_t              in_item,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  aml_sts_pkg::out_item_t             out_item,
  output int                                 fail_count,
  output int                                 expected_left
);

  // Mirror of the configuration registers.
  logic [aml_sts_pkg::BODY_LEN_W-1:0] body_len;
  logic [aml_sts_pkg::TARGET_W-1:0]   target;

  // Scan state of the predictor.
  logic [aml_sts_pkg::POSITION_BITS_DEF-1:0] position;
  logic [23:0]                               recent;
  aml_sts_pkg::phase_t                       phase;
  logic [1:0]                                len_left;
  logic [7:0]                                held_a;

  aml_sts_pkg::out_item_t pending_status[$];
  int                     errors = 0;
  int                     left_count = 0;

  assign fail_count    = errors;
  assign expected_left = left_count;

  // Advances the scan by one body byte; returns 1 when the scan ends with a result.
  function automatic bit advance_scan(input logic [7:0] d, input logic r,
                                      output aml_sts_pkg::out_item_t res);
    int unsigned          pos;
    int unsigned          blen;
    int unsigned          k;
    logic [23:0]          pattern;
    logic [7:0]           type_b;
    bit                   ended;
    aml_sts_pkg::status_t st;
    ended  = 1'b0;
    st     = aml_sts_pkg::ST_FOUND;
    type_b = '0;
    res    = '0;
    if (r) begin
      position = '0;
      recent   = '0;
      phase    = aml_sts_pkg::PH_SEARCH;
      len_left = '0;
      held_a   = '0;
    end
    if (phase == aml_sts_pkg::PH_DONE) return 1'b0;

    pos     = 32'(position);
    blen    = 32'(body_len);
    pattern = {aml_sts_pkg::CHAR_UNDERSCORE, aml_sts_pkg::CHAR_S,
               aml_sts_pkg::CHAR_ZERO + 8'(target)};

    case (phase)
      aml_sts_pkg::PH_SEARCH: begin
        if (recent == pattern && d == aml_sts_pkg::CHAR_UNDERSCORE && pos + 5 < blen)
          phase = aml_sts_pkg::PH_PKG_OP;
      end
      aml_sts_pkg::PH_PKG_OP: phase = aml_sts_pkg::PH_LEAD;
      aml_sts_pkg::PH_LEAD: begin
        k = 32'(d[7:6]);
        if (!(pos + 3 + k < blen)) begin
          ended = 1'b1;
          st    = aml_sts_pkg::ST_OUT_OF_TABLE;
        end else if (k == 0) begin
          phase = aml_sts_pkg::PH_COUNT;
        end else begin
          len_left = k[1:0];
          phase    = aml_sts_pkg::PH_LENGTH;
        end
      end
      aml_sts_pkg::PH_LENGTH: begin
        len_left = len_left - 2'd1;
        if (len_left == 2'd0) phase = aml_sts_pkg::PH_COUNT;
      end
      aml_sts_pkg::PH_COUNT: phase = aml_sts_pkg::PH_PREFIX_A;
      aml_sts_pkg::PH_PREFIX_A: begin
        if (d == aml_sts_pkg::BYTE_PREFIX) begin
          phase = aml_sts_pkg::PH_VALUE_A;
        end else begin
          held_a = d;
          phase  = aml_sts_pkg::PH_PREFIX_B;
        end
      end
      aml_sts_pkg::PH_VALUE_A: begin
        held_a = d;
        phase  = aml_sts_pkg::PH_PREFIX_B;
      end
      aml_sts_pkg::PH_PREFIX_B: begin
        if (d == aml_sts_pkg::BYTE_PREFIX) begin
          phase = aml_sts_pkg::PH_VALUE_B;
        end else begin
          type_b = d;
          ended  = 1'b1;
        end
      end
      aml_sts_pkg::PH_VALUE_B: begin
        type_b = d;
        ended  = 1'b1;
      end
      default: begin
        phase = aml_sts_pkg::PH_DONE;
        return 1'b0;
      end
    endcase

    recent = {recent[15:0], d};

    // Running into the last body byte ends the scan.
    if (!ended && pos + 1 >= blen) begin
      ended = 1'b1;
      st    = (phase == aml_sts_pkg::PH_SEARCH) ? aml_sts_pkg::ST_NOT_FOUND :
                                                  aml_sts_pkg::ST_OUT_OF_TABLE;
    end

    if (position != '1) position = position + 1'b1;

    if (!ended) return 1'b0;

    phase      = aml_sts_pkg::PH_DONE;
    res.status = st;
    if (st == aml_sts_pkg::ST_FOUND) begin
      res.sleep_type_a = held_a;
      res.sleep_type_b = type_b;
    end
    return 1'b1;
  endfunction

  // Predict on every accepted item, compare every accepted result item.
  always @(posedge clk) begin : watch
    aml_sts_pkg::out_item_t predicted;
    aml_sts_pkg::out_item_t want;
    if (!rst_n) begin
      body_len   = '0;
      target     = aml_sts_pkg::TARGET_RESET;
      position   = '0;
      recent     = '0;
      phase      = aml_sts_pkg::PH_SEARCH;
      len_left   = '0;
      held_a     = '0;
      pending_status.delete();
      left_count <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        if (advance_scan(in_item.data_byte, in_item.restart, predicted))
          pending_status.push_back(predicted);
      end

      if (cfg_we) begin
        if (cfg_index == aml_sts_pkg::REG_BODY_LENGTH)
          body_len = cfg_wdata[aml_sts_pkg::BODY_LEN_W-1:0];
        else target = cfg_wdata[aml_sts_pkg::TARGET_W-1:0];
      end

      if (out_valid && !out_stall) begin
        if (pending_status.size() == 0) begin
          $error("result item with no expected status waiting: status %0d, a %0d, b %0d",
                 out_item.status, out_item.sleep_type_a, out_item.sleep_type_b);
          errors++;
        end else begin
          want = pending_status.pop_front();
          if (out_item.status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, out_item.status);
            errors++;
          end
          if (out_item.sleep_type_a !== want.sleep_type_a) begin
            $error("sleep_type_a mismatch: expected %0d, actual %0d",
                   want.sleep_type_a, out_item.sleep_type_a);
            errors++;
          end
          if (out_item.sleep_type_b !== want.sleep_type_b) begin
            $error("sleep_type_b mismatch: expected %0d, actual %0d",
                   want.sleep_type_b, out_item.sleep_type_b);
            errors++;
          end
        end
      end
      left_count <= pending_status.size();
    end
  end

endmodule

// ----- dv/tb_aml_sleep_type_scanner.sv -----
// Testbench top for the sleep-type scanner: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_aml_sleep_type_scanner;

  localparam logic [7:0] PACKAGE_OP = 8'h12;

  logic                               clk       = 1'b0;
  logic                               rst_n     = 1'b0;
  logic                               cfg_we    = 1'b0;
  logic                               cfg_index = aml_sts_pkg::REG_BODY_LENGTH;
  logic [aml_sts_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                               in_valid  = 1'b0;
  logic                               in_stall;
  aml_sts_pkg::in_item_t              in_item   = '0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  aml_sts_pkg::out_item_t             out_item;

  int fail_count;
  int expected_left;

  // Current register settings and stimulus knobs.
  logic [aml_sts_pkg::BODY_LEN_W-1:0] cur_len    = '0;
  logic [aml_sts_pkg::TARGET_W-1:0]   cur_target = aml_sts_pkg::TARGET_RESET;
  bit                                 calm       = 1'b0;
  int                                 item_count = 0;

  always #5 clk = ~clk;

  aml_sleep_type_scanner uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  sleep_type_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_item       (in_item),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_item      (out_item),
    .fail_count    (fail_count),
    .expected_left (expected_left)
  );

  // Receiver back-pressure, off during the calm stretch.
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 14);
  end

  // Sends one body byte and returns at the edge where it is accepted.
  task automatic send_byte(input logic [7:0] d, input logic r);
    while (!calm && $urandom_range(0, 99) < 14) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_item.data_byte <= d;
    in_item.restart   <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Holds the sender off until every expected result item has come.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_left != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Writes the body length register, then the target state register.
  task automatic write_config(input logic [aml_sts_pkg::BODY_LEN_W-1:0] blen,
                              input logic [aml_sts_pkg::TARGET_W-1:0] tgt);
    cur_len    = blen;
    cur_target = tgt;
    cfg_we    <= 1'b1;
    cfg_index <= aml_sts_pkg::REG_BODY_LENGTH;
    cfg_wdata <= aml_sts_pkg::CFG_DATA_W'(blen);
    @(posedge clk);
    cfg_index <= aml_sts_pkg::REG_TARGET_STATE;
    cfg_wdata <= aml_sts_pkg::CFG_DATA_W'(tgt);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Filler byte, biased toward the characters of the name.
  function automatic logic [7:0] filler();
    case ($urandom_range(0, 9))
      0:       return aml_sts_pkg::CHAR_UNDERSCORE;
      1:       return aml_sts_pkg::CHAR_S;
      2:       return aml_sts_pkg::CHAR_ZERO + 8'(cur_target);
      default: return 8'($urandom);
    endcase
  endfunction

  // Builds one table body, mostly a well-formed sleep package, and streams it.
  task automatic run_table();
    logic [7:0] body[$];
    int         kind;
    int         k;
    int         cut;
    kind = int'($urandom_range(0, 99));
    repeat ($urandom_range(0, 5)) body.push_back(filler());
    if (kind < 70) begin
      body.push_back(aml_sts_pkg::CHAR_UNDERSCORE);
      body.push_back(aml_sts_pkg::CHAR_S);
      body.push_back(aml_sts_pkg::CHAR_ZERO + 8'(cur_target));
      body.push_back(aml_sts_pkg::CHAR_UNDERSCORE);
      body.push_back(PACKAGE_OP);
      k = int'($urandom_range(0, 3));
      body.push_back({2'(k), 6'($urandom_range(0, 63))});
      repeat (k) body.push_back(8'($urandom));
      body.push_back(8'($urandom_range(1, 8)));
      if ($urandom_range(0, 1)) body.push_back(aml_sts_pkg::BYTE_PREFIX);
      body.push_back(8'($urandom));
      if ($urandom_range(0, 1)) body.push_back(aml_sts_pkg::BYTE_PREFIX);
      body.push_back(8'($urandom));
    end else if (kind < 85) begin
      // Partial name or a name with a random digit.
      body.push_back(aml_sts_pkg::CHAR_UNDERSCORE);
      body.push_back(aml_sts_pkg::CHAR_S);
      if ($urandom_range(0, 1))
        body.push_back(aml_sts_pkg::CHAR_ZERO + 8'($urandom_range(0, 7)));
      body.push_back(aml_sts_pkg::CHAR_UNDERSCORE);
    end
    repeat ($urandom_range(0, 6)) body.push_back(filler());
    // Short tables often run to their end so the not-found path is taken.
    if (cur_len <= 64 && $urandom_range(0, 1)) begin
      while (body.size() < cur_len + 2) body.push_back(filler());
    end
    // Now and then cut the table short; the next restart breaks the scan.
    if ($urandom_range(0, 9) == 0) begin
      cut = int'($urandom_range(1, body.size()));
      while (body.size() > cut) void'(body.pop_back());
    end
    for (int i = 0; i < body.size(); i++) begin
      send_byte(body[i], (i == 0) || ($urandom_range(0, 199) == 0));
      item_count++;
    end
  endtask

  initial begin : stimulus
    int phase_idx;
    int tables;
    int guard;
    phase_idx = 0;
    guard     = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Zero body length from reset, with no restart: the first byte ends the scan.
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    wait_drained();

    // One package with both prefixes under the reset target.
    write_config(20'd14, aml_sts_pkg::TARGET_RESET);
    send_byte(aml_sts_pkg::CHAR_UNDERSCORE, 1'b1);
    send_byte(aml_sts_pkg::CHAR_S, 1'b0);
    send_byte(aml_sts_pkg::CHAR_ZERO + 8'(aml_sts_pkg::TARGET_RESET), 1'b0);
    send_byte(aml_sts_pkg::CHAR_UNDERSCORE, 1'b0);
    send_byte(PACKAGE_OP, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(aml_sts_pkg::BYTE_PREFIX, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(aml_sts_pkg::BYTE_PREFIX, 1'b0);
    send_byte(8'h02, 1'b0);
    wait_drained();

    // Random phases, each under its own register setting.
    while (item_count < 1350) begin
      case (phase_idx)
        0:       write_config(20'd0, 3'd0);
        1:       write_config(20'd1, 3'd7);
        2:       write_config(20'hFFFFF, 3'd6);
        3:       write_config(20'd9, 3'd3);
        4:       write_config(20'd8, 3'd5);
        default: write_config(20'($urandom_range(6, 48)), 3'($urandom_range(0, 7)));
      endcase
      calm   = (phase_idx == 5);
      tables = calm ? 16 : int'($urandom_range(3, 8));
      repeat (tables) run_table();
      wait_drained();
      calm = 1'b0;
      phase_idx++;
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_left != 0 && guard < 10000) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);

    if (fail_count == 0 && expected_left == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
